/* rtl/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg
// Shared sizes, opcodes, fault codes and item types of the stack VM core.
// ----------------------------------------------------------------------------
package svm_pkg;

   // storage sizes
   localparam int DS_DEPTH = 64;
   localparam int DS_AW    = $clog2(DS_DEPTH);
   localparam int DD_W     = DS_AW + 1;
   localparam int RS_DEPTH = 32;
   localparam int RS_AW    = $clog2(RS_DEPTH);
   localparam int RD_W     = RS_AW + 1;
   localparam int SS_WORDS = 256;
   localparam int SS_AW    = $clog2(SS_WORDS);
   localparam int CODE_AW  = 16;
   localparam int DATA_W   = 64;
   localparam int WORD_W   = 32;

   // opcodes
   localparam logic [5:0] OP_ADD    = 6'd0;
   localparam logic [5:0] OP_SUB    = 6'd1;
   localparam logic [5:0] OP_MUL    = 6'd2;
   localparam logic [5:0] OP_DIV    = 6'd3;
   localparam logic [5:0] OP_MOD    = 6'd4;
   localparam logic [5:0] OP_SHL    = 6'd5;
   localparam logic [5:0] OP_SHR    = 6'd6;
   localparam logic [5:0] OP_AND    = 6'd7;
   localparam logic [5:0] OP_OR     = 6'd8;
   localparam logic [5:0] OP_XOR    = 6'd9;
   localparam logic [5:0] OP_NOT    = 6'd10;
   localparam logic [5:0] OP_LAND   = 6'd11;
   localparam logic [5:0] OP_LOR    = 6'd12;
   localparam logic [5:0] OP_LNOT   = 6'd13;
   localparam logic [5:0] OP_DUP    = 6'd14;
   localparam logic [5:0] OP_DUP2   = 6'd15;
   localparam logic [5:0] OP_OVER   = 6'd16;
   localparam logic [5:0] OP_OVER2  = 6'd17;
   localparam logic [5:0] OP_SWAP   = 6'd18;
   localparam logic [5:0] OP_SWAP2  = 6'd19;
   localparam logic [5:0] OP_FETCH  = 6'd20;
   localparam logic [5:0] OP_STORE  = 6'd21;
   localparam logic [5:0] OP_GOTO   = 6'd22;
   localparam logic [5:0] OP_GOZ    = 6'd23;
   localparam logic [5:0] OP_CALL   = 6'd24;
   localparam logic [5:0] OP_RET    = 6'd25;
   localparam logic [5:0] OP_SYSC   = 6'd26;
   localparam logic [5:0] OP_CONST  = 6'd27;
   localparam logic [5:0] OP_DROP   = 6'd28;
   localparam logic [5:0] OP_DROP2  = 6'd29;
   localparam logic [5:0] OP_RSV0   = 6'd30;
   localparam logic [5:0] OP_RSV1   = 6'd31;
   localparam logic [5:0] OP_SYSRET = 6'd32;
   localparam logic [5:0] OP_INPUT  = 6'd33;
   localparam logic [5:0] OP_OUTPUT = 6'd34;
   localparam logic [5:0] OP_SETDB  = 6'd35;
   localparam logic [5:0] OP_SETCB  = 6'd36;
   localparam logic [5:0] OP_USER   = 6'd37;
   localparam logic [5:0] OP_TERM   = 6'd38;

   // syscall numbers
   localparam logic [63:0] SYS_READ  = 64'd0;
   localparam logic [63:0] SYS_WRITE = 64'd1;
   localparam logic [63:0] SYS_EXIT  = 64'd2;

   // fault codes
   localparam logic [2:0] FLT_NONE    = 3'd0;
   localparam logic [2:0] FLT_ILLEGAL = 3'd1;
   localparam logic [2:0] FLT_PRIV    = 3'd2;
   localparam logic [2:0] FLT_BOUNDS  = 3'd3;
   localparam logic [2:0] FLT_SYSCALL = 3'd4;
   localparam logic [2:0] FLT_ADDR    = 3'd5;
   localparam logic [2:0] FLT_DIVZERO = 3'd6;
   localparam logic [2:0] FLT_STACK   = 3'd7;

   typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_kind_type;

   typedef enum logic [1:0] {MDS_IDLE, MDS_MUL, MDS_DIV, MDS_FIX} md_state_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_RD1, ST_RD2, ST_EXEC, ST_WR1, ST_ARITH, ST_PUSH
   } bk_state_type;

   // classified instruction item
   typedef struct packed {
      logic [5:0]        opcode;
      logic [WORD_W-1:0] inline_word;
      logic [WORD_W-1:0] input_value;
      logic              illegal;
      logic              priv;
      logic [1:0]        need;
      logic [1:0]        grow;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [CODE_AW-1:0] next_ip;
      logic               output_valid;
      logic [DATA_W-1:0]  output_value;
      logic               input_taken;
      logic               halted;
      logic [2:0]         fault_code;
   } rsp_item_type;

endpackage

/* rtl/svm_front.sv */
// ----------------------------------------------------------------------------
// svm_front
// Accepts instruction items, classifies them and holds them in a two-entry
// queue for the execution back end.
// ----------------------------------------------------------------------------
module svm_front import svm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [5:0]         req_opcode,
   input  logic [WORD_W-1:0]  req_inline_word,
   input  logic [WORD_W-1:0]  req_input_value,
   output logic               item_valid,
   output req_item_type       item,
   input  logic               item_deq
);

   req_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   req_item_type cls;
   logic         enq;

   // classify: legality, privilege, stack entries needed and added
   always_comb begin
      cls.opcode      = req_opcode;
      cls.inline_word = req_inline_word;
      cls.input_value = req_input_value;
      cls.illegal     = (req_opcode > OP_TERM) || (req_opcode == OP_RSV0) ||
                        (req_opcode == OP_RSV1);
      cls.priv        = (req_opcode >= OP_SYSRET);
      case (req_opcode)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_AND, OP_OR,
         OP_XOR, OP_LAND, OP_LOR, OP_OVER, OP_SWAP, OP_STORE, OP_DROP2,
         OP_SETDB, OP_SETCB: cls.need = 2'd2;
         OP_OVER2, OP_SWAP2: cls.need = 2'd3;
         OP_NOT, OP_LNOT, OP_DUP, OP_DUP2, OP_FETCH, OP_GOZ, OP_SYSC, OP_DROP,
         OP_OUTPUT: cls.need = 2'd1;
         default: cls.need = 2'd0;
      endcase
      case (req_opcode)
         OP_DUP, OP_OVER, OP_OVER2, OP_CONST, OP_INPUT: cls.grow = 2'd1;
         OP_DUP2: cls.grow = 2'd2;
         default: cls.grow = 2'd0;
      endcase
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign enq        = push && !full;

   // queue pointers
   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_deq ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, enq} - {1'b0, item_deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (enq) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* rtl/svm_muldiv.sv */
// ----------------------------------------------------------------------------
// svm_muldiv
// Iterative 64-bit multiplier (three 32x32 partial products) and restoring
// signed divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module svm_muldiv import svm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              md_start,
   input  md_kind_type       md_kind,
   input  logic [DATA_W-1:0] md_lhs,
   input  logic [DATA_W-1:0] md_rhs,
   output logic              md_done,
   output logic [DATA_W-1:0] md_result
);

   md_state_type      state_ff, state_in;
   logic [5:0]        step_ff;
   logic [DATA_W-1:0] x_ff, y_ff, acc_ff, prod_ff, rem_ff, result_ff;
   logic              neg_q_ff, neg_r_ff, is_mod_ff, done_ff;
   logic [31:0]       mul_x, mul_y;
   logic [DATA_W:0]   shifted, trial;

   assign md_done   = done_ff;
   assign md_result = result_ff;

   // partial product operand select
   always_comb begin
      mul_x = x_ff[31:0];
      mul_y = y_ff[31:0];
      case (step_ff[1:0])
         2'd1: mul_y = y_ff[63:32];
         2'd2: mul_x = x_ff[63:32];
         default: ;
      endcase
   end

   // restoring divide step
   assign shifted = {rem_ff, x_ff[63]};
   assign trial   = shifted - {1'b0, y_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MDS_IDLE: if (md_start) state_in = (md_kind == MD_MUL) ? MDS_MUL : MDS_DIV;
         MDS_MUL:  if (step_ff == 6'd3) state_in = MDS_IDLE;
         MDS_DIV:  if (step_ff == 6'd63) state_in = MDS_FIX;
         MDS_FIX:  state_in = MDS_IDLE;
         default:  state_in = MDS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MDS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= ((state_ff == MDS_MUL) && (step_ff == 6'd3)) ||
                     (state_ff == MDS_FIX);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         MDS_IDLE: begin
            step_ff   <= 6'd0;
            acc_ff    <= '0;
            rem_ff    <= '0;
            is_mod_ff <= (md_kind == MD_MOD);
            neg_q_ff  <= md_lhs[63] ^ md_rhs[63];
            neg_r_ff  <= md_lhs[63];
            if (md_kind == MD_MUL) begin
               x_ff <= md_lhs;
               y_ff <= md_rhs;
            end else begin
               x_ff <= md_lhs[63] ? (64'd0 - md_lhs) : md_lhs;
               y_ff <= md_rhs[63] ? (64'd0 - md_rhs) : md_rhs;
            end
         end
         MDS_MUL: begin
            step_ff <= step_ff + 6'd1;
            prod_ff <= mul_x * mul_y;
            case (step_ff[1:0])
               2'd1: acc_ff <= prod_ff;
               2'd2: acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
               2'd3: result_ff <= acc_ff + {prod_ff[31:0], 32'd0};
               default: ;
            endcase
         end
         MDS_DIV: begin
            step_ff <= step_ff + 6'd1;
            if (trial[DATA_W]) begin
               rem_ff <= shifted[DATA_W-1:0];
               x_ff   <= {x_ff[62:0], 1'b0};
            end else begin
               rem_ff <= trial[DATA_W-1:0];
               x_ff   <= {x_ff[62:0], 1'b1};
            end
         end
         MDS_FIX: begin
            if (is_mod_ff) begin
               result_ff <= neg_r_ff ? (64'd0 - rem_ff) : rem_ff;
            end else begin
               result_ff <= neg_q_ff ? (64'd0 - x_ff) : x_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

/* rtl/svm_back.sv */
// ----------------------------------------------------------------------------
// svm_back
// Execution back end: sequencer, data and return stacks, static memory,
// instruction pointer, privilege mode and user bounds.
// ----------------------------------------------------------------------------
module svm_back import svm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         item_deq,
   input  logic         rsp_room,
   output logic         rsp_push,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic         csr_bit
);

   bk_state_type        state_ff, state_in;
   req_item_type        op_ff;
   logic [DATA_W-1:0]   a_ff, b_ff;
   logic [DD_W-1:0]     dd_ff;
   logic [RD_W-1:0]     rd_ff;
   logic [CODE_AW-1:0]  ip_ff;
   logic                sup_ff, stopped_ff;
   logic [SS_AW-1:0]    dlo_ff, dhi_ff;
   logic [CODE_AW-1:0]  clo_ff, chi_ff;
   logic [DS_AW-1:0]    w1_addr_ff;
   logic [DATA_W-1:0]   w1_data_ff;
   rsp_item_type        rsp_ff;

   // memories
   logic [DATA_W-1:0]   ds_mem [DS_DEPTH];
   logic [DATA_W-1:0]   ds_rdata_ff;
   logic [CODE_AW-1:0]  rs_mem [RS_DEPTH];
   logic [CODE_AW-1:0]  rs_rdata_ff;
   logic [DATA_W-1:0]   ss_mem [SS_WORDS];
   logic [SS_WORDS-1:0] ss_valid_ff;
   logic [DATA_W-1:0]   ss_rdata_ff;
   logic                ss_rvalid_ff;

   logic                ds_we;
   logic [DS_AW-1:0]    ds_waddr, ds_raddr;
   logic [DATA_W-1:0]   ds_wdata;

   // derived values
   logic [DD_W-1:0]     d_m1, d_m2, d_m3, d_p1;
   logic [RD_W-1:0]     rd_m1;
   logic [DATA_W-1:0]   wx, ix, cval, ssv;
   logic [CODE_AW-1:0]  ip_p1, ip_p2;
   logic [7:0]          room_sum;
   logic [2:0]          chk_fault;

   // execute results
   logic [2:0]          ex_fault;
   logic [CODE_AW-1:0]  ex_nip;
   logic [DD_W-1:0]     ex_nd;
   logic                w0_en, w1_en;
   logic [DS_AW-1:0]    w0_addr, w1_addr;
   logic [DATA_W-1:0]   w0_data, w1_data;
   logic                ss_we_ex, rs_push, rs_pop, sup_set, sup_clr;
   logic                set_db, set_cb, ex_halt, ex_ovalid, ex_itaken, ex_arith;
   logic [DATA_W-1:0]   ex_oval;
   logic                bad_bounds;
   logic [DATA_W-1:0]   bound_lim;
   md_kind_type         md_kind;
   logic                md_start, md_done;
   logic [DATA_W-1:0]   md_result;

   function automatic logic in_range(input logic [DATA_W-1:0] v,
                                     input logic [CODE_AW-1:0] lo,
                                     input logic [CODE_AW-1:0] hi);
      in_range = ($signed(v) >= $signed({48'd0, lo})) &&
                 ($signed(v) <= $signed({48'd0, hi}));
   endfunction

   assign d_m1     = dd_ff - 7'd1;
   assign d_m2     = dd_ff - 7'd2;
   assign d_m3     = dd_ff - 7'd3;
   assign d_p1     = dd_ff + 7'd1;
   assign rd_m1    = rd_ff - 6'd1;
   assign ip_p1    = ip_ff + 16'd1;
   assign ip_p2    = ip_ff + 16'd2;
   assign wx       = {{32{op_ff.inline_word[31]}}, op_ff.inline_word};
   assign ix       = {{32{op_ff.input_value[31]}}, op_ff.input_value};
   assign cval     = ds_rdata_ff;
   assign ssv      = ss_rvalid_ff ? ss_rdata_ff : '0;
   assign room_sum = {1'b0, dd_ff} + {6'd0, op_ff.grow};
   assign rsp_item = rsp_ff;

   // illegal, privilege and stack depth checks
   always_comb begin
      chk_fault = FLT_NONE;
      if (op_ff.illegal) begin
         chk_fault = FLT_ILLEGAL;
      end else if (op_ff.priv && !sup_ff) begin
         chk_fault = FLT_PRIV;
      end else if ((dd_ff < {5'd0, op_ff.need}) || (room_sum > 8'(DS_DEPTH))) begin
         chk_fault = FLT_STACK;
      end
   end

   // set-bounds validity
   always_comb begin
      bound_lim  = (op_ff.opcode == OP_SETDB) ? 64'(SS_WORDS) : 64'(1 << CODE_AW);
      bad_bounds = ($signed(a_ff) < $signed(b_ff)) || b_ff[63] || a_ff[63] ||
                   (a_ff >= bound_lim);
   end

   // execute one instruction
   always_comb begin
      ex_fault  = FLT_NONE;
      ex_nip    = ip_p1;
      ex_nd     = dd_ff;
      w0_en     = 1'b0;
      w0_addr   = d_m1[DS_AW-1:0];
      w0_data   = '0;
      w1_en     = 1'b0;
      w1_addr   = d_m2[DS_AW-1:0];
      w1_data   = a_ff;
      ss_we_ex  = 1'b0;
      rs_push   = 1'b0;
      rs_pop    = 1'b0;
      sup_set   = 1'b0;
      sup_clr   = 1'b0;
      set_db    = 1'b0;
      set_cb    = 1'b0;
      ex_halt   = 1'b0;
      ex_ovalid = 1'b0;
      ex_oval   = '0;
      ex_itaken = 1'b0;
      ex_arith  = 1'b0;
      md_kind   = MD_MUL;
      case (op_ff.opcode)
         OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_AND, OP_OR, OP_XOR, OP_LAND, OP_LOR: begin
            w0_en   = 1'b1;
            w0_addr = d_m2[DS_AW-1:0];
            ex_nd   = d_m1;
            case (op_ff.opcode)
               OP_ADD:  w0_data = b_ff + a_ff;
               OP_SUB:  w0_data = b_ff - a_ff;
               OP_SHL:  w0_data = b_ff << a_ff[5:0];
               OP_SHR:  w0_data = 64'($signed(b_ff) >>> a_ff[5:0]);
               OP_AND:  w0_data = b_ff & a_ff;
               OP_OR:   w0_data = b_ff | a_ff;
               OP_XOR:  w0_data = b_ff ^ a_ff;
               OP_LAND: w0_data = {63'd0, (b_ff != '0) && (a_ff != '0)};
               default: w0_data = {63'd0, (b_ff != '0) || (a_ff != '0)};
            endcase
         end
         OP_MUL: ex_arith = 1'b1;
         OP_DIV, OP_MOD: begin
            md_kind = (op_ff.opcode == OP_DIV) ? MD_DIV : MD_MOD;
            if (a_ff == '0) ex_fault = FLT_DIVZERO;
            else ex_arith = 1'b1;
         end
         OP_NOT: begin
            w0_en   = 1'b1;
            w0_data = ~a_ff;
         end
         OP_LNOT: begin
            w0_en   = 1'b1;
            w0_data = {63'd0, a_ff == '0};
         end
         OP_DUP, OP_OVER, OP_OVER2: begin
            w0_en   = 1'b1;
            w0_addr = dd_ff[DS_AW-1:0];
            ex_nd   = d_p1;
            case (op_ff.opcode)
               OP_DUP:  w0_data = a_ff;
               OP_OVER: w0_data = b_ff;
               default: w0_data = cval;
            endcase
         end
         OP_DUP2: begin
            w0_en   = 1'b1;
            w0_addr = dd_ff[DS_AW-1:0];
            w0_data = a_ff;
            w1_en   = 1'b1;
            w1_addr = d_p1[DS_AW-1:0];
            ex_nd   = dd_ff + 7'd2;
         end
         OP_SWAP: begin
            w0_en   = 1'b1;
            w0_data = b_ff;
            w1_en   = 1'b1;
         end
         OP_SWAP2: begin
            w0_en   = 1'b1;
            w0_data = cval;
            w1_en   = 1'b1;
            w1_addr = d_m3[DS_AW-1:0];
         end
         OP_FETCH, OP_STORE: begin
            if (!in_range(a_ff, {8'd0, dlo_ff}, {8'd0, dhi_ff}) ||
                (a_ff[31:0] >= 32'(SS_WORDS))) begin
               ex_fault = FLT_ADDR;
            end else if (op_ff.opcode == OP_FETCH) begin
               w0_en   = 1'b1;
               w0_data = ssv;
            end else begin
               ss_we_ex = 1'b1;
               ex_nd    = d_m2;
            end
         end
         OP_GOTO: begin
            if (!in_range(wx, clo_ff, chi_ff)) ex_fault = FLT_ADDR;
            ex_nip = op_ff.inline_word[CODE_AW-1:0];
         end
         OP_GOZ: begin
            ex_nd = d_m1;
            if (a_ff == '0) begin
               if (!in_range(wx, clo_ff, chi_ff)) ex_fault = FLT_ADDR;
               ex_nip = op_ff.inline_word[CODE_AW-1:0];
            end else begin
               ex_nip = ip_p2;
            end
         end
         OP_CALL: begin
            if (rd_ff >= RD_W'(RS_DEPTH)) ex_fault = FLT_STACK;
            else if (!in_range(wx, clo_ff, chi_ff)) ex_fault = FLT_ADDR;
            rs_push = 1'b1;
            ex_nip  = op_ff.inline_word[CODE_AW-1:0];
         end
         OP_RET, OP_SYSRET: begin
            if (rd_ff == '0) ex_fault = FLT_STACK;
            else if (!in_range({48'd0, rs_rdata_ff}, clo_ff, chi_ff)) ex_fault = FLT_ADDR;
            rs_pop  = 1'b1;
            ex_nip  = rs_rdata_ff;
            sup_clr = (op_ff.opcode == OP_SYSRET);
         end
         OP_SYSC: begin
            sup_set = 1'b1;
            case (a_ff)
               SYS_READ: begin
                  w0_en     = 1'b1;
                  w0_data   = ix;
                  ex_itaken = 1'b1;
               end
               SYS_WRITE: begin
                  if (dd_ff < 7'd2) ex_fault = FLT_STACK;
                  ex_ovalid = 1'b1;
                  ex_oval   = b_ff;
                  ex_nd     = d_m2;
               end
               SYS_EXIT: begin
                  ex_nd   = d_m1;
                  ex_halt = 1'b1;
               end
               default: ex_fault = FLT_SYSCALL;
            endcase
         end
         OP_CONST: begin
            w0_en   = 1'b1;
            w0_addr = dd_ff[DS_AW-1:0];
            w0_data = wx;
            ex_nd   = d_p1;
            ex_nip  = ip_p2;
         end
         OP_DROP:  ex_nd = d_m1;
         OP_DROP2: ex_nd = d_m2;
         OP_INPUT: begin
            w0_en     = 1'b1;
            w0_addr   = dd_ff[DS_AW-1:0];
            w0_data   = ix;
            ex_nd     = d_p1;
            ex_itaken = 1'b1;
         end
         OP_OUTPUT: begin
            ex_ovalid = 1'b1;
            ex_oval   = a_ff;
            ex_nd     = d_m1;
         end
         OP_SETDB, OP_SETCB: begin
            if (bad_bounds) ex_fault = FLT_BOUNDS;
            set_db = (op_ff.opcode == OP_SETDB);
            set_cb = (op_ff.opcode == OP_SETCB);
            ex_nd  = d_m2;
         end
         OP_USER: begin
            ex_nip  = clo_ff;
            sup_clr = 1'b1;
         end
         OP_TERM: ex_halt = 1'b1;
         default: ;
      endcase
   end

   // sequencer: next state and memory port control
   always_comb begin
      state_in = state_ff;
      item_deq = 1'b0;
      md_start = 1'b0;
      rsp_push = 1'b0;
      ds_raddr = d_m1[DS_AW-1:0];
      ds_we    = 1'b0;
      ds_waddr = w0_addr;
      ds_wdata = w0_data;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid && rsp_room) begin
               item_deq = 1'b1;
               state_in = stopped_ff ? ST_PUSH : ST_CHECK;
            end
         end
         ST_CHECK: state_in = (chk_fault != FLT_NONE) ? ST_PUSH : ST_RD1;
         ST_RD1: begin
            ds_raddr = d_m2[DS_AW-1:0];
            state_in = ST_RD2;
         end
         ST_RD2: begin
            ds_raddr = d_m3[DS_AW-1:0];
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ex_fault != FLT_NONE) begin
               state_in = ST_PUSH;
            end else if (ex_arith) begin
               md_start = 1'b1;
               state_in = ST_ARITH;
            end else begin
               ds_we    = w0_en;
               state_in = w1_en ? ST_WR1 : ST_PUSH;
            end
         end
         ST_WR1: begin
            ds_we    = 1'b1;
            ds_waddr = w1_addr_ff;
            ds_wdata = w1_data_ff;
            state_in = ST_PUSH;
         end
         ST_ARITH: begin
            if (md_done) begin
               ds_we    = 1'b1;
               ds_waddr = d_m2[DS_AW-1:0];
               ds_wdata = md_result;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         dd_ff        <= '0;
         rd_ff        <= '0;
         ip_ff        <= '0;
         sup_ff       <= 1'b1;
         stopped_ff   <= 1'b0;
         dlo_ff       <= '0;
         dhi_ff       <= '0;
         clo_ff       <= '0;
         chi_ff       <= '0;
         ss_valid_ff  <= '0;
      end else begin
         if ((state_ff == ST_CHECK) && (chk_fault != FLT_NONE)) stopped_ff <= 1'b1;
         if (state_ff == ST_EXEC) begin
            if (ex_fault != FLT_NONE) begin
               stopped_ff <= 1'b1;
            end else if (!ex_arith) begin
               dd_ff      <= ex_nd;
               ip_ff      <= ex_nip;
               stopped_ff <= ex_halt;
               if (rs_push) rd_ff <= rd_ff + 6'd1;
               if (rs_pop) rd_ff <= rd_m1;
               if (sup_set) sup_ff <= 1'b1;
               if (sup_clr) sup_ff <= 1'b0;
               if (ss_we_ex) ss_valid_ff[a_ff[SS_AW-1:0]] <= 1'b1;
               if (set_db) begin
                  dlo_ff <= b_ff[SS_AW-1:0];
                  dhi_ff <= a_ff[SS_AW-1:0];
               end
               if (set_cb) begin
                  clo_ff <= b_ff[CODE_AW-1:0];
                  chi_ff <= a_ff[CODE_AW-1:0];
               end
            end
         end
         if ((state_ff == ST_ARITH) && md_done) begin
            dd_ff <= d_m1;
            ip_ff <= ip_p1;
         end
         if (csr_we) begin
            sup_ff <= csr_bit;
         end
      end
   end

   // item payload, operands and result register
   always_ff @(posedge clock) begin
      if (item_deq) op_ff <= item;
      if (state_ff == ST_RD1) a_ff <= ds_rdata_ff;
      if (state_ff == ST_RD2) b_ff <= ds_rdata_ff;
      if (state_ff == ST_EXEC) begin
         w1_addr_ff <= w1_addr;
         w1_data_ff <= w1_data;
      end
      case (state_ff)
         ST_IDLE: rsp_ff <= '{next_ip: ip_ff, output_valid: 1'b0, output_value: '0,
                              input_taken: 1'b0, halted: 1'b1, fault_code: FLT_NONE};
         ST_CHECK: rsp_ff <= '{next_ip: ip_ff, output_valid: 1'b0, output_value: '0,
                               input_taken: 1'b0, halted: 1'b1, fault_code: chk_fault};
         ST_EXEC: begin
            if (ex_fault != FLT_NONE) begin
               rsp_ff <= '{next_ip: ip_ff, output_valid: 1'b0, output_value: '0,
                           input_taken: 1'b0, halted: 1'b1, fault_code: ex_fault};
            end else begin
               rsp_ff <= '{next_ip: ex_nip, output_valid: ex_ovalid,
                           output_value: ex_oval, input_taken: ex_itaken,
                           halted: ex_halt, fault_code: FLT_NONE};
            end
         end
         ST_ARITH: rsp_ff <= '{next_ip: ip_p1, output_valid: 1'b0, output_value: '0,
                               input_taken: 1'b0, halted: 1'b0, fault_code: FLT_NONE};
         default: ;
      endcase
   end

   // data stack memory
   always_ff @(posedge clock) begin
      if (ds_we) ds_mem[ds_waddr] <= ds_wdata;
      ds_rdata_ff <= ds_mem[ds_raddr];
   end

   // return stack memory
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EXEC) && (ex_fault == FLT_NONE) && rs_push) begin
         rs_mem[rd_ff[RS_AW-1:0]] <= ip_p2;
      end
      rs_rdata_ff <= rs_mem[rd_m1[RS_AW-1:0]];
   end

   // static memory; entries never stored read as zero
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EXEC) && (ex_fault == FLT_NONE) && ss_we_ex) begin
         ss_mem[a_ff[SS_AW-1:0]] <= b_ff;
      end
      ss_rdata_ff  <= ss_mem[a_ff[SS_AW-1:0]];
      ss_rvalid_ff <= ss_valid_ff[a_ff[SS_AW-1:0]];
   end

   svm_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .md_start  (md_start),
      .md_kind   (md_kind),
      .md_lhs    (b_ff),
      .md_rhs    (a_ff),
      .md_done   (md_done),
      .md_result (md_result)
   );

endmodule

/* rtl/stack_vm_instruction_executor.sv */
// Sequence: an accepted item passes the back-end states check, rd1, rd2,
//   exec and push; dup2, swap and swap2 add wr1, and mul, div and mod wait
//   in arith on the iterative multiply/divide unit; an illegal, privileged or
//   stack-depth fault goes from check to push, a stopped machine idle to push.
// Throughput: one item at a time, set by the sequencer and its data stack port.
// Reset: synchronous; stacks empty, ip 0, bounds 0, supervisor mode, static
//   memory reads zero at once through per-word valid bits.
// ----------------------------------------------------------------------------
// stack_vm_instruction_executor
// Two-stack VM core: a front queue classifies instructions, a back end
// executes them and results leave through a two-entry queue.
// ----------------------------------------------------------------------------
module stack_vm_instruction_executor import svm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [5:0]          req_opcode,
   input  logic signed [31:0]  req_inline_word,
   input  logic signed [31:0]  req_input_value,
   output logic                empty,
   input  logic                pop,
   output logic [15:0]         rsp_next_ip,
   output logic                rsp_output_valid,
   output logic signed [63:0]  rsp_output_value,
   output logic                rsp_input_taken,
   output logic                rsp_halted,
   output logic [2:0]          rsp_fault_code,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);

   logic         item_valid, item_deq, rsp_push;
   req_item_type item;
   rsp_item_type rsp_in;
   rsp_item_type oq_ff [2];
   logic         oq_wr_ff, oq_rd_ff;
   logic [1:0]   oq_count_ff;
   logic         oq_pop;
   rsp_item_type head;

   assign csr_ready = 1'b1;

   svm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_opcode      (req_opcode),
      .req_inline_word (req_inline_word),
      .req_input_value (req_input_value),
      .item_valid      (item_valid),
      .item            (item),
      .item_deq        (item_deq)
   );

   svm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_deq   (item_deq),
      .rsp_room   (oq_count_ff != 2'd2),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_in),
      .csr_we     (csr_valid && csr_ready),
      .csr_bit    (csr_data)
   );

   // result queue
   assign oq_pop = pop && !empty;
   assign empty  = (oq_count_ff == 2'd0);
   assign head   = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= 2'd0;
      end else begin
         if (rsp_push) oq_wr_ff <= ~oq_wr_ff;
         if (oq_pop) oq_rd_ff <= ~oq_rd_ff;
         oq_count_ff <= oq_count_ff + {1'b0, rsp_push} - {1'b0, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) oq_ff[oq_wr_ff] <= rsp_in;
   end

   assign rsp_next_ip      = head.next_ip;
   assign rsp_output_valid = head.output_valid;
   assign rsp_output_value = head.output_value;
   assign rsp_input_taken  = head.input_taken;
   assign rsp_halted       = head.halted;
   assign rsp_fault_code   = head.fault_code;

endmodule
